@@ rtl/mcst_pkg.sv @@
package mcst_pkg;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_CREATE = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_START  = 3'd3,
		CMD_STOP   = 3'd4,
		CMD_QUERY  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FREE    = 2'd0,
		ST_STOPPED = 2'd1,
		ST_RUNNING = 2'd2
	} tstat_t;

	typedef enum logic [1:0] {
		K_DONE    = 2'd0,
		K_EXPIRED = 2'd1,
		K_REJECT  = 2'd2,
		K_IDLE    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_READ,
		FSM_EXEC,
		FSM_SCAN_RD,
		FSM_SCAN_EV,
		FSM_SCAN_WAIT,
		FSM_SCAN_END,
		FSM_OUT
	} fsm_t;

	// Controller to datapath
	typedef struct packed {
		logic load_cmd;
		logic rd_entry;
		logic exec;
		logic scan_start;
		logic scan_eval;
		logic scan_next;
		logic scan_close;
		logic out_take;
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic is_tick;
		logic scan_done;
		logic out_full;
		logic out_valid;
	} sts_t;

	localparam int KIND_W = 2;
	localparam int ID_W   = 4;
	localparam int LEFT_W = 32;
	localparam int DLY_W  = 32;

endpackage

@@ rtl/mcst_if.sv @@
interface mcst_in_if;
	import mcst_pkg::*;
	logic              valid;
	logic              ready;
	logic [2:0]        cmd;
	logic [ID_W-1:0]   timer_id;
	logic              periodic;
	logic [DLY_W-1:0]  delay_ticks;
	modport source (output valid, cmd, timer_id, periodic, delay_ticks, input ready);
	modport sink (input valid, cmd, timer_id, periodic, delay_ticks, output ready);
endinterface

interface mcst_out_if;
	import mcst_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   result_id;
	logic [1:0]        timer_state;
	logic [LEFT_W-1:0] left_ticks;
	logic              last;
	modport source (output valid, kind, result_id, timer_state, left_ticks, last, input ready);
	modport sink (input valid, kind, result_id, timer_state, left_ticks, last, output ready);
endinterface

@@ rtl/mcst_datapath.sv @@
module mcst_datapath
	import mcst_pkg::*;
#(
	parameter int TIMERS    = 16,
	parameter int TICK_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	output sts_t                sts,
	input  logic [2:0]          in_cmd,
	input  logic [ID_W-1:0]     in_id,
	input  logic                in_per,
	input  logic [DLY_W-1:0]    in_dly,
	output logic [KIND_W-1:0]   o_kind,
	output logic [ID_W-1:0]     o_id,
	output logic [1:0]          o_state,
	output logic [LEFT_W-1:0]   o_left,
	output logic                o_last
);
	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CW = $clog2(TIMERS + 1);
	localparam logic [CW-1:0] FULL = CW'(TIMERS);
	localparam logic [TICK_BITS-1:0] TMAX = '1;

	// Per-timer memories and the per-timer state array
	logic                 per_mem   [TIMERS];
	logic [TICK_BITS-1:0] dly_mem   [TIMERS];
	logic [TICK_BITS-1:0] start_mem [TIMERS];
	logic [IW-1:0]        fq_mem    [TIMERS];
	tstat_t               stat_q    [TIMERS];

	logic [TICK_BITS-1:0] tick_q;
	logic [IW-1:0]        head_q;
	logic [CW-1:0]        fcount_q;
	logic [CW-1:0]        fq_init_q;

	logic [2:0]           cmd_q;
	logic [ID_W-1:0]      id_q;
	logic                 per_q;
	logic [DLY_W-1:0]     dly_q;

	logic [IW-1:0]        scan_q;
	logic                 scan_end_q;
	logic                 hit_q;
	logic [IW-1:0]        pend_id_q;
	logic [1:0]           pend_st_q;

	logic                 rd_per_q;
	logic [TICK_BITS-1:0] rd_dly_q;
	logic [TICK_BITS-1:0] rd_start_q;
	logic [IW-1:0]        rd_fq_q;

	logic                 ov_q;
	logic [KIND_W-1:0]    okind_q;
	logic [ID_W-1:0]      oid_q;
	logic [1:0]           ostate_q;
	logic [LEFT_W-1:0]    oleft_q;
	logic                 olast_q;

	logic                 id_ok;
	logic [IW-1:0]        tid;
	logic [IW-1:0        ] rd_addr;
	logic [CW:0]          tail_sum;
	logic [IW-1:0]        tail_idx;
	logic [TICK_BITS-1:0] elapsed;
	logic                 due;
	logic                 scan_hit;
	logic [TICK_BITS-1:0] dly_sat;
	logic [TICK_BITS-1:0] left_full;
	logic [IW-1:0]        fq_pick;
	tstat_t               s_cur;

	assign id_ok   = ({{(32-ID_W){1'b0}}, id_q} < 32'(TIMERS));
	assign tid     = IW'(id_q);
	assign rd_addr = ctl.rd_entry ? (cmd_q == CMD_TICK ? scan_q : tid) : tid;
	assign tail_sum = (CW+1)'(head_q) + (CW+1)'(fcount_q);
	assign tail_idx = (tail_sum >= (CW+1)'(TIMERS)) ? IW'(tail_sum - (CW+1)'(TIMERS))
		: IW'(tail_sum);
	assign elapsed = tick_q - rd_start_q;
	assign due     = (elapsed >= rd_dly_q);
	assign scan_hit = (stat_q[scan_q] == ST_RUNNING) && due;
	assign left_full = rd_dly_q - elapsed;
	assign s_cur   = stat_q[tid];
	// slots from fq_init_q up were never written; their entry is taken to be their own index
	assign fq_pick = (CW'(head_q) < fq_init_q) ? rd_fq_q : head_q;

	generate
		if (DLY_W > TICK_BITS) begin : g_sat
			assign dly_sat = (dly_q > DLY_W'(TMAX)) ? TMAX : dly_q[TICK_BITS-1:0];
		end else begin : g_ext
			assign dly_sat = TICK_BITS'(dly_q);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (ctl.load_cmd) begin
			cmd_q <= in_cmd;
			id_q  <= in_id;
			per_q <= in_per;
			dly_q <= in_dly;
		end
		if (ctl.rd_entry) begin
			rd_per_q   <= per_mem[rd_addr];
			rd_dly_q   <= dly_mem[rd_addr];
			rd_start_q <= start_mem[rd_addr];
			rd_fq_q    <= fq_mem[head_q];
		end
		if (ctl.exec) begin
			if (cmd_q == CMD_CREATE && fcount_q != '0) begin
				per_mem[fq_pick] <= per_q;
				dly_mem[fq_pick] <= dly_sat;
			end
			if (cmd_q == CMD_DELETE && id_ok && s_cur != ST_FREE && fcount_q < FULL)
				fq_mem[tail_idx] <= tid;
			if (cmd_q == CMD_START && id_ok && s_cur == ST_STOPPED)
				start_mem[tid] <= tick_q;
		end
		if (ctl.scan_eval && scan_hit && rd_per_q)
			start_mem[scan_q] <= tick_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMERS; i++) stat_q[i] <= ST_FREE;
			tick_q     <= '0;
			head_q     <= '0;
			fcount_q   <= FULL;
			fq_init_q  <= '0;
			scan_q     <= '0;
			scan_end_q <= 1'b0;
			hit_q      <= 1'b0;
			pend_id_q  <= '0;
			pend_st_q  <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (ctl.out_take) ov_q <= 1'b0;
			if (ctl.scan_start) begin
				tick_q     <= tick_q + 1'b1;
				scan_q     <= '0;
				scan_end_q <= 1'b0;
				hit_q      <= 1'b0;
			end
			if (ctl.scan_next) begin
				if (32'(scan_q) == TIMERS - 1) scan_end_q <= 1'b1;
				else scan_q <= scan_q + 1'b1;
			end
			if (ctl.scan_eval && scan_hit) begin
				// hold this expiry back one hit so the final one can carry last
				hit_q     <= 1'b1;
				if (!rd_per_q) stat_q[scan_q] <= ST_STOPPED;
				pend_id_q <= scan_q;
				pend_st_q <= rd_per_q ? ST_RUNNING : ST_STOPPED;
				if (hit_q) begin
					ov_q     <= 1'b1;
					okind_q  <= K_EXPIRED;
					oid_q    <= ID_W'(pend_id_q);
					ostate_q <= pend_st_q;
					oleft_q  <= '0;
					olast_q  <= 1'b0;
				end
			end
			if (ctl.scan_close) begin
				// end of pass: flush the held expiry, or an idle beat
				ov_q    <= 1'b1;
				oleft_q <= '0;
				olast_q <= 1'b1;
				if (hit_q) begin
					okind_q  <= K_EXPIRED;
					oid_q    <= ID_W'(pend_id_q);
					ostate_q <= pend_st_q;
				end else begin
					okind_q  <= K_IDLE;
					oid_q    <= '0;
					ostate_q <= ST_FREE;
				end
			end
			if (ctl.exec) begin
				ov_q    <= 1'b1;
				olast_q <= 1'b1;
				oleft_q <= '0;
				oid_q   <= id_q;
				ostate_q <= ST_FREE;
				okind_q <= K_REJECT;
				if (cmd_q == CMD_CREATE) begin
					oid_q <= '0;
					if (fcount_q != '0) begin
						stat_q[fq_pick] <= ST_STOPPED;
						head_q   <= (32'(head_q) == TIMERS - 1) ? '0 : head_q + 1'b1;
						fcount_q <= fcount_q - 1'b1;
						okind_q  <= K_DONE;
						oid_q    <= ID_W'(fq_pick);
						ostate_q <= ST_STOPPED;
					end
				end else if (id_ok) begin
					unique case (cmd_q)
						CMD_DELETE: begin
							okind_q  <= K_DONE;
							ostate_q <= s_cur;
							if (s_cur != ST_FREE && fcount_q < FULL) begin
								stat_q[tid] <= ST_FREE;
								fcount_q    <= fcount_q + 1'b1;
								ostate_q    <= ST_FREE;
								if (CW'(tail_idx) == fq_init_q && fq_init_q < FULL)
									fq_init_q <= fq_init_q + 1'b1;
							end
						end
						CMD_START: begin
							ostate_q <= s_cur;
							if (s_cur == ST_STOPPED) begin
								stat_q[tid] <= ST_RUNNING;
								okind_q     <= K_DONE;
								ostate_q    <= ST_RUNNING;
							end
						end
						CMD_STOP: begin
							ostate_q <= s_cur;
							if (s_cur == ST_RUNNING) begin
								stat_q[tid] <= ST_STOPPED;
								okind_q     <= K_DONE;
								ostate_q    <= ST_STOPPED;
							end
						end
						CMD_QUERY: begin
							okind_q  <= K_DONE;
							ostate_q <= s_cur;
							if (s_cur == ST_RUNNING && !due)
								oleft_q <= LEFT_W'(left_full);
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign sts.is_tick   = (cmd_q == CMD_TICK);
	assign sts.scan_done = scan_end_q;
	assign sts.out_full  = ov_q && !ctl.out_take;
	assign sts.out_valid = ov_q;

	assign o_kind  = okind_q;
	assign o_id    = oid_q;
	assign o_state = ostate_q;
	assign o_left  = oleft_q;
	assign o_last  = olast_q;

`ifndef SYNTHESIS
	a_fcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= FULL) else $error("free count above pool size");
	a_tick_adv: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_start |=> tick_q == $past(tick_q) + 1'b1)
		else $error("tick count did not advance");
	a_create_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && cmd_q == CMD_CREATE && fcount_q == '0 |=> fcount_q == '0)
		else $error("create on empty pool changed count");
`endif
endmodule

@@ rtl/mcst_ctrl.sv @@
module mcst_ctrl
	import mcst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_ready,
	input  logic out_last,
	input  sts_t sts,
	output ctl_t ctl
);
	fsm_t state_q, state_d;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_d;
	end

	assign take = sts.out_valid && out_ready;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		ctl.out_take = take;
		unique case (state_q)
			FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_cmd = 1'b1;
					state_d = FSM_READ;
				end
			end
			FSM_READ: begin
				if (sts.is_tick) begin
					ctl.scan_start = 1'b1;
					state_d = FSM_SCAN_RD;
				end else begin
					ctl.rd_entry = 1'b1;
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				ctl.exec = 1'b1;
				state_d = FSM_OUT;
			end
			FSM_SCAN_RD: begin
				ctl.rd_entry = 1'b1;
				state_d = FSM_SCAN_EV;
			end
			FSM_SCAN_EV: begin
				// hold while a beat is still in the output register
				if (!sts.out_full) begin
					ctl.scan_eval = 1'b1;
					ctl.scan_next = 1'b1;
					state_d = FSM_SCAN_WAIT;
				end
			end
			FSM_SCAN_WAIT: begin
				state_d = sts.scan_done ? FSM_SCAN_END : FSM_SCAN_RD;
			end
			FSM_SCAN_END: begin
				if (!sts.out_full) begin
					ctl.scan_close = 1'b1;
					state_d = FSM_OUT;
				end
			end
			FSM_OUT: begin
				if (take && out_last) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == FSM_IDLE) else $error("ready outside idle");
	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> !ctl.exec) else $error("double execute");
	a_eval_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_eval |-> !sts.out_full) else $error("result overwritten");
`endif
endmodule

@@ rtl/multi_channel_soft_timer_pool.sv @@
// Create/delete/start/stop/query pass through read and execute states and present their one
// beat from the output register; the next command is accepted only once that beat is taken.
// A tick walks all TIMERS entries through read, evaluate and step states, then a close state;
// evaluate and close wait while the output register is full. One item is in work at a time.
// Each expiry is held back one hit so the final one carries last; no expiry gives an idle beat.
// arst_n clears the state machine, all timer states, the tick count and free queue.
module multi_channel_soft_timer_pool
	import mcst_pkg::*;
#(
	parameter int TIMERS    = 16,
	parameter int TICK_BITS = 32
) (
	input logic  clk,
	input logic  arst_n,
	mcst_in_if.sink    cmd_in,
	mcst_out_if.source res_out
);
	ctl_t ctl;
	sts_t sts;

	mcst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_in.valid),
		.in_ready  (cmd_in.ready),
		.out_ready (res_out.ready),
		.out_last  (res_out.last),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Datapath: timer memories, free queue, scan counter and the output register
	mcst_datapath #(.TIMERS(TIMERS), .TICK_BITS(TICK_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sts     (sts),
		.in_cmd  (cmd_in.cmd),
		.in_id   (cmd_in.timer_id),
		.in_per  (cmd_in.periodic),
		.in_dly  (cmd_in.delay_ticks),
		.o_kind  (res_out.kind),
		.o_id    (res_out.result_id),
		.o_state (res_out.timer_state),
		.o_left  (res_out.left_ticks),
		.o_last  (res_out.last)
	);

	assign res_out.valid = sts.out_valid;
endmodule
